/* design/srcp_pkg.sv */
// Package for the segment / rectangle crossing block.
// Holds the edge count and the per-item control flags used by several modules.
package srcp_pkg;

  // Number of rectangle edges (left, right, top, bottom), one divider lane each.
  localparam int NUM_EDGES = 4;

  // Edge lanes in the order in which crossings are collected.
  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_BOTTOM = 3;

  // Per-item control flags that travel beside the data.
  typedef struct packed {
    logic miss;   // segment bounding box misses the rectangle
    logic has_x;  // dx is nonzero, left and right crossings exist
    logic has_y;  // dy is nonzero, top and bottom crossings exist
  } srcp_ctl_t;

endpackage

/* design/segment_rect_clip_points.sv */
// Segment against rectangle crossing points, fully pipelined. An item enters
// every cycle and passes through two front-end stages, COORD_BITS+3 divider
// stages (an entry stage, then one quotient bit per stage), and two back-end
// stages ending in the output register. When the output item is not taken, the
// whole pipeline holds and in_ready_o drops; no item is lost or repeated.
// Depends on srcp_pkg.
module segment_rect_clip_points #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] rect_x_i,
  input  logic signed [COORD_BITS-1:0] rect_y_i,
  input  logic        [COORD_BITS-2:0] rect_w_i,
  input  logic        [COORD_BITS-2:0] rect_h_i,
  input  logic signed [COORD_BITS-1:0] seg_ax_i,
  input  logic signed [COORD_BITS-1:0] seg_ay_i,
  input  logic signed [COORD_BITS-1:0] seg_bx_i,
  input  logic signed [COORD_BITS-1:0] seg_by_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] first_x_o,
  output logic signed [COORD_BITS-1:0] first_y_o,
  output logic signed [COORD_BITS-1:0] second_x_o,
  output logic signed [COORD_BITS-1:0] second_y_o
);
  import srcp_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DL = C + 3;
  localparam int SB = 4 * C + 2 * (C + 1) + $bits(srcp_ctl_t);

  // The pipeline moves as one whenever the output register can take an item.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic                valid_p;
  logic [2*C:0]        prod_p [NUM_EDGES];
  logic [C-1:0]        dvs_p  [NUM_EDGES];
  logic                neg_p  [NUM_EDGES];
  logic signed [C-1:0] rx_p, ry_p, ax_p, ay_p;
  logic signed [C:0]   right_p, bottom_p;
  srcp_ctl_t           ctl_p;

  srcp_prep #(.C(C)) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .rect_x_i (rect_x_i),
    .rect_y_i (rect_y_i),
    .rect_w_i (rect_w_i),
    .rect_h_i (rect_h_i),
    .seg_ax_i (seg_ax_i),
    .seg_ay_i (seg_ay_i),
    .seg_bx_i (seg_bx_i),
    .seg_by_i (seg_by_i),
    .valid_o  (valid_p),
    .prod_o   (prod_p),
    .dvs_o    (dvs_p),
    .neg_o    (neg_p),
    .rx_o     (rx_p),
    .ry_o     (ry_p),
    .right_o  (right_p),
    .bottom_o (bottom_p),
    .ax_o     (ax_p),
    .ay_o     (ay_p),
    .ctl_o    (ctl_p)
  );

  // One divider lane per rectangle edge.
  logic [C+2:0] mag_d [NUM_EDGES];
  logic         neg_d [NUM_EDGES];

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_lane
    srcp_div #(.C(C)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .prod_i (prod_p[k]),
      .dvs_i  (dvs_p[k]),
      .neg_i  (neg_p[k]),
      .mag_o  (mag_d[k]),
      .neg_o  (neg_d[k])
    );
  end

  // Edge positions and flags ride beside the divider lanes.
  logic          vd_q [DL];
  logic [SB-1:0] sd_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else if (en) begin
      vd_q[0] <= valid_p;
      for (int k = 1; k < DL; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= {rx_p, ry_p, right_p, bottom_p, ax_p, ay_p, ctl_p};
      for (int k = 1; k < DL; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  logic signed [C-1:0] rx_s, ry_s, ax_s, ay_s;
  logic signed [C:0]   right_s, bottom_s;
  srcp_ctl_t           ctl_s;

  assign {rx_s, ry_s, right_s, bottom_s, ax_s, ay_s, ctl_s} = sd_q[DL-1];

  srcp_pick #(.C(C)) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vd_q[DL-1]),
    .mag_i      (mag_d),
    .neg_i      (neg_d),
    .rx_i       (rx_s),
    .ry_i       (ry_s),
    .right_i    (right_s),
    .bottom_i   (bottom_s),
    .ax_i       (ax_s),
    .ay_i       (ay_s),
    .ctl_i      (ctl_s),
    .valid_o    (out_valid_o),
    .hit_o      (hit_o),
    .first_x_o  (first_x_o),
    .first_y_o  (first_y_o),
    .second_x_o (second_x_o),
    .second_y_o (second_y_o)
  );

  // A result without a hit carries zero coordinates.
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> first_x_o == '0 && first_y_o == '0 &&
                              second_x_o == '0 && second_y_o == '0)
    else $error("no-hit result with nonzero coordinates");

  // A waiting result stalls the input side.
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the output item waits");

  // A held output item does not advance the last side stage.
  a_hold_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vd_q[DL-1]) && out_valid_o)
    else $error("pipeline moved during a stall");

endmodule

/* design/srcp_prep.sv */
// Front end: edge offsets, deltas, bounding box test and the four products.
// Two register stages. Depends on srcp_pkg.
module srcp_prep #(
  parameter int C = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [C-1:0]     rect_x_i,
  input  logic signed [C-1:0]     rect_y_i,
  input  logic        [C-2:0]     rect_w_i,
  input  logic        [C-2:0]     rect_h_i,
  input  logic signed [C-1:0]     seg_ax_i,
  input  logic signed [C-1:0]     seg_ay_i,
  input  logic signed [C-1:0]     seg_bx_i,
  input  logic signed [C-1:0]     seg_by_i,
  output logic                    valid_o,
  output logic        [2*C:0]     prod_o [srcp_pkg::NUM_EDGES],
  output logic        [C-1:0]     dvs_o  [srcp_pkg::NUM_EDGES],
  output logic                    neg_o  [srcp_pkg::NUM_EDGES],
  output logic signed [C-1:0]     rx_o,
  output logic signed [C-1:0]     ry_o,
  output logic signed [C:0]       right_o,
  output logic signed [C:0]       bottom_o,
  output logic signed [C-1:0]     ax_o,
  output logic signed [C-1:0]     ay_o,
  output srcp_pkg::srcp_ctl_t     ctl_o
);
  import srcp_pkg::*;

  // Stage one: offsets and deltas.
  logic signed [C:0]   right_d, bottom_d, dx_d, dy_d;
  logic signed [C-1:0] xmin, xmax, ymin, ymax;
  logic signed [C+1:0] num_d [NUM_EDGES];
  srcp_ctl_t           ctl_d;

  always_comb begin
    right_d  = $signed({rect_x_i[C-1], rect_x_i}) + $signed({2'b00, rect_w_i});
    bottom_d = $signed({rect_y_i[C-1], rect_y_i}) + $signed({2'b00, rect_h_i});
    dx_d     = $signed({seg_bx_i[C-1], seg_bx_i}) - $signed({seg_ax_i[C-1], seg_ax_i});
    dy_d     = $signed({seg_by_i[C-1], seg_by_i}) - $signed({seg_ay_i[C-1], seg_ay_i});
    xmin     = (seg_ax_i < seg_bx_i) ? seg_ax_i : seg_bx_i;
    xmax     = (seg_ax_i < seg_bx_i) ? seg_bx_i : seg_ax_i;
    ymin     = (seg_ay_i < seg_by_i) ? seg_ay_i : seg_by_i;
    ymax     = (seg_ay_i < seg_by_i) ? seg_by_i : seg_ay_i;
    num_d[EDGE_LEFT]   = $signed({{2{rect_x_i[C-1]}}, rect_x_i})
                       - $signed({{2{seg_ax_i[C-1]}}, seg_ax_i});
    num_d[EDGE_RIGHT]  = $signed({right_d[C], right_d})
                       - $signed({{2{seg_ax_i[C-1]}}, seg_ax_i});
    num_d[EDGE_TOP]    = $signed({{2{rect_y_i[C-1]}}, rect_y_i})
                       - $signed({{2{seg_ay_i[C-1]}}, seg_ay_i});
    num_d[EDGE_BOTTOM] = $signed({bottom_d[C], bottom_d})
                       - $signed({{2{seg_ay_i[C-1]}}, seg_ay_i});
    ctl_d.miss  = (right_d < $signed({xmin[C-1], xmin})) || (rect_x_i > xmax) ||
                  (bottom_d < $signed({ymin[C-1], ymin})) || (rect_y_i > ymax);
    ctl_d.has_x = (dx_d != '0);
    ctl_d.has_y = (dy_d != '0);
  end

  logic signed [C+1:0] num_q [NUM_EDGES];
  logic signed [C:0]   dx_q, dy_q, right_q, bottom_q;
  logic signed [C-1:0] rx_q, ry_q, ax_q, ay_q;
  srcp_ctl_t           ctl_q;
  logic                v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q    <= num_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
      rx_q     <= rect_x_i;
      ry_q     <= rect_y_i;
      ax_q     <= seg_ax_i;
      ay_q     <= seg_ay_i;
      ctl_q    <= ctl_d;
    end
  end

  // Stage two: magnitudes, products and quotient signs.
  logic [C+1:0] nneg  [NUM_EDGES];
  logic [C:0]   nmag  [NUM_EDGES];
  logic [C:0]   bsrc  [NUM_EDGES];
  logic [C:0]   csrc  [NUM_EDGES];
  logic [C:0]   bneg  [NUM_EDGES];
  logic [C:0]   cneg  [NUM_EDGES];
  logic [C-1:0] bmag  [NUM_EDGES];
  logic [C-1:0] cmag  [NUM_EDGES];
  logic [2*C:0] prod_d [NUM_EDGES];
  logic         neg_d  [NUM_EDGES];

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      // Vertical edges scale by dy over dx, horizontal edges by dx over dy.
      bsrc[k]   = (k < EDGE_TOP) ? dy_q : dx_q;
      csrc[k]   = (k < EDGE_TOP) ? dx_q : dy_q;
      nneg[k]   = -num_q[k];
      bneg[k]   = -bsrc[k];
      cneg[k]   = -csrc[k];
      nmag[k]   = num_q[k][C+1] ? nneg[k][C:0] : num_q[k][C:0];
      bmag[k]   = bsrc[k][C] ? bneg[k][C-1:0] : bsrc[k][C-1:0];
      cmag[k]   = csrc[k][C] ? cneg[k][C-1:0] : csrc[k][C-1:0];
      prod_d[k] = nmag[k] * bmag[k];
      neg_d[k]  = num_q[k][C+1] ^ bsrc[k][C] ^ csrc[k][C];
    end
  end

  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o   <= prod_d;
      dvs_o    <= cmag;
      neg_o    <= neg_d;
      rx_o     <= rx_q;
      ry_o     <= ry_q;
      right_o  <= right_q;
      bottom_o <= bottom_q;
      ax_o     <= ax_q;
      ay_o     <= ay_q;
      ctl_o    <= ctl_q;
    end
  end

  assign valid_o = v2_q;

endmodule

/* design/srcp_div.sv */
// Pipelined restoring divider lane: entry stage, then a quotient bit per stage.
// Quotients too large for any crossing are flagged and clamped. No package use.
module srcp_div #(
  parameter int C = 24
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*C:0]   prod_i,
  input  logic [C-1:0]   dvs_i,
  input  logic           neg_i,
  output logic [C+2:0]   mag_o,
  output logic           neg_o
);
  localparam int QB = C + 2;
  localparam int PW = 2 * C + 1;

  logic [C-1:0]  rem_q  [QB+1];
  logic [QB-1:0] nq_q   [QB+1];
  logic [C-1:0]  d_q    [QB+1];
  logic          neg_q  [QB+1];
  logic          over_q [QB+1];

  // Entry stage: a quotient of 2^QB or more cannot land on an edge span.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, prod_i[PW-1:QB]};
      nq_q[0]   <= prod_i[QB-1:0];
      d_q[0]    <= dvs_i;
      neg_q[0]  <= neg_i;
      over_q[0] <= ({1'b0, prod_i[PW-1:QB]} >= dvs_i);
    end
  end

  // Each stage brings down one dividend bit and shifts in one quotient bit.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [C:0]   r2;
    logic [C:0]   sub;
    logic         ge;
    logic [C-1:0] rem_n;

    always_comb begin
      r2    = {rem_q[k-1], nq_q[k-1][QB-1]};
      sub   = r2 - {1'b0, d_q[k-1]};
      ge    = (r2 >= {1'b0, d_q[k-1]});
      rem_n = ge ? sub[C-1:0] : r2[C-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_n;
        nq_q[k]   <= {nq_q[k-1][QB-2:0], ge};
        d_q[k]    <= d_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        over_q[k] <= over_q[k-1];
      end
    end
  end

  assign mag_o = over_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, nq_q[QB]};
  assign neg_o = neg_q[QB];

endmodule

/* design/srcp_pick.sv */
// Back end: crossing points, span tests, saturation and choice of two points.
// Two register stages, the second is the output register. Depends on srcp_pkg.
module srcp_pick #(
  parameter int C = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [C+2:0]          mag_i [srcp_pkg::NUM_EDGES],
  input  logic                  neg_i [srcp_pkg::NUM_EDGES],
  input  logic signed [C-1:0]   rx_i,
  input  logic signed [C-1:0]   ry_i,
  input  logic signed [C:0]     right_i,
  input  logic signed [C:0]     bottom_i,
  input  logic signed [C-1:0]   ax_i,
  input  logic signed [C-1:0]   ay_i,
  input  srcp_pkg::srcp_ctl_t   ctl_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic signed [C-1:0]   first_x_o,
  output logic signed [C-1:0]   first_y_o,
  output logic signed [C-1:0]   second_x_o,
  output logic signed [C-1:0]   second_y_o
);
  import srcp_pkg::*;

  localparam int MW = C + 3;
  localparam int SW = C + 5;
  localparam logic signed [SW-1:0] MAXV = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

  function automatic logic [C-1:0] sat(input logic signed [SW-1:0] v);
    logic [C-1:0] r;
    if (v > MAXV) begin
      r = MAXV[C-1:0];
    end else if (v < MINV) begin
      r = MINV[C-1:0];
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  // Stage A: crossing coordinates at full width and the closed span tests.
  logic signed [SW-1:0] qv   [NUM_EDGES];
  logic signed [SW-1:0] qs   [NUM_EDGES];
  logic signed [SW-1:0] cv   [NUM_EDGES];
  logic signed [SW-1:0] ex   [NUM_EDGES];
  logic signed [SW-1:0] lo   [NUM_EDGES];
  logic signed [SW-1:0] hi   [NUM_EDGES];
  logic signed [SW-1:0] rx_e, ry_e, right_e, bottom_e, ax_e, ay_e;
  logic                 ok_d [NUM_EDGES];
  logic [C-1:0]         xs_d [NUM_EDGES];
  logic [C-1:0]         ys_d [NUM_EDGES];

  always_comb begin
    rx_e     = {{(SW-C){rx_i[C-1]}}, rx_i};
    ry_e     = {{(SW-C){ry_i[C-1]}}, ry_i};
    ax_e     = {{(SW-C){ax_i[C-1]}}, ax_i};
    ay_e     = {{(SW-C){ay_i[C-1]}}, ay_i};
    right_e  = {{(SW-C-1){right_i[C]}}, right_i};
    bottom_e = {{(SW-C-1){bottom_i[C]}}, bottom_i};
    for (int k = 0; k < NUM_EDGES; k++) begin
      qv[k] = {{(SW-MW){1'b0}}, mag_i[k]};
      qs[k] = neg_i[k] ? -qv[k] : qv[k];
      // The fixed coordinate of the edge and the computed one.
      case (k)
        EDGE_LEFT:   ex[k] = rx_e;
        EDGE_RIGHT:  ex[k] = right_e;
        EDGE_TOP:    ex[k] = ry_e;
        default:     ex[k] = bottom_e;
      endcase
      cv[k] = ((k < EDGE_TOP) ? ay_e : ax_e) + qs[k];
      lo[k] = (k < EDGE_TOP) ? ry_e : rx_e;
      hi[k] = (k < EDGE_TOP) ? bottom_e : right_e;
      ok_d[k] = !ctl_i.miss && ((k < EDGE_TOP) ? ctl_i.has_x : ctl_i.has_y) &&
                (cv[k] >= lo[k]) && (cv[k] <= hi[k]);
      xs_d[k] = sat((k < EDGE_TOP) ? ex[k] : cv[k]);
      ys_d[k] = sat((k < EDGE_TOP) ? cv[k] : ex[k]);
    end
  end

  logic         va_q;
  logic         ok_q [NUM_EDGES];
  logic [C-1:0] xs_q [NUM_EDGES];
  logic [C-1:0] ys_q [NUM_EDGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= ok_d;
      xs_q <= xs_d;
      ys_q <= ys_d;
    end
  end

  // Stage B: take the first two crossings in edge order.
  logic         f1, f2;
  logic [C-1:0] fx, fy, sx, sy;

  always_comb begin
    f1 = 1'b0;
    f2 = 1'b0;
    fx = '0;
    fy = '0;
    sx = '0;
    sy = '0;
    for (int k = 0; k < NUM_EDGES; k++) begin
      if (ok_q[k]) begin
        if (!f1) begin
          f1 = 1'b1;
          fx = xs_q[k];
          fy = ys_q[k];
        end else if (!f2) begin
          f2 = 1'b1;
          sx = xs_q[k];
          sy = ys_q[k];
        end
      end
    end
  end

  logic vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= va_q;
    end
  end

  // A single crossing reports as no hit with zero coordinates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o      <= f2;
      first_x_o  <= f2 ? fx : '0;
      first_y_o  <= f2 ? fy : '0;
      second_x_o <= f2 ? sx : '0;
      second_y_o <= f2 ? sy : '0;
    end
  end

  assign valid_o = vo_q;

endmodule

/* test/testbench.sv */
// Self-checking testbench for segment_rect_clip_points.
// Drives rectangle/segment items with random gaps and predicts each crossing result.
// Depends only on the block under test and srcp_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int W = 24;
  localparam int LATENCY = W + 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (W - 1));

  typedef struct {
    logic signed [W-1:0] rect_x;
    logic signed [W-1:0] rect_y;
    logic [W-2:0]        rect_w;
    logic [W-2:0]        rect_h;
    logic signed [W-1:0] seg_ax;
    logic signed [W-1:0] seg_ay;
    logic signed [W-1:0] seg_bx;
    logic signed [W-1:0] seg_by;
  } query_t;

  typedef struct {
    logic                hit;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;
  } crossing_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [W-1:0] rect_x_i, rect_y_i, seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i;
  logic [W-2:0] rect_w_i, rect_h_i;
  logic hit_o;
  logic signed [W-1:0] first_x_o, first_y_o, second_x_o, second_y_o;

  query_t    pending_q[$];
  crossing_t crossings_q[$];
  int        error_count = 0;
  int        taken_count = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 0;

  segment_rect_clip_points #(.COORD_BITS(W)) uut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Saturate an exact coordinate to the output range.
  function automatic logic signed [W-1:0] clamp_coord(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[W-1:0];
  endfunction

  // Crossings of the segment's line with left, right, top and bottom edges.
  function automatic crossing_t predict_crossings(query_t q);
    longint rx, ry, right, bottom, ax, ay, bx, by, dx, dy, c;
    longint px[2], py[2];
    int n;
    crossing_t r;
    rx = q.rect_x; ry = q.rect_y;
    right = rx + longint'({1'b0, q.rect_w});
    bottom = ry + longint'({1'b0, q.rect_h});
    ax = q.seg_ax; ay = q.seg_ay; bx = q.seg_bx; by = q.seg_by;
    dx = bx - ax; dy = by - ay;
    n = 0;
    r = '{default: '0};
    // Products stay below 2^52, so plain 64-bit division truncates exactly.
    if (right < ((ax < bx) ? ax : bx) || rx > ((ax < bx) ? bx : ax) ||
        bottom < ((ay < by) ? ay : by) || ry > ((ay < by) ? by : ay))
      return r;
    if (dx != 0) begin
      c = ay + (rx - ax) * dy / dx;
      if (c >= ry && c <= bottom && n < 2) begin px[n] = rx; py[n] = c; n++; end
      c = ay + (right - ax) * dy / dx;
      if (c >= ry && c <= bottom && n < 2) begin px[n] = right; py[n] = c; n++; end
    end
    if (dy != 0) begin
      c = ax + (ry - ay) * dx / dy;
      if (c >= rx && c <= right && n < 2) begin px[n] = c; py[n] = ry; n++; end
      c = ax + (bottom - ay) * dx / dy;
      if (c >= rx && c <= right && n < 2) begin px[n] = c; py[n] = bottom; n++; end
    end
    if (n == 2) begin
      r.hit = 1'b1;
      r.first_x = clamp_coord(px[0]);
      r.first_y = clamp_coord(py[0]);
      r.second_x = clamp_coord(px[1]);
      r.second_y = clamp_coord(py[1]);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             taken_count);
    error_count++;
  endtask

  function automatic query_t make_query(longint rx, longint ry, longint rw, longint rh,
                                        longint ax, longint ay, longint bx, longint by);
    query_t q;
    q.rect_x = clamp_coord(rx); q.rect_y = clamp_coord(ry);
    q.rect_w = rw[W-2:0]; q.rect_h = rh[W-2:0];
    q.seg_ax = clamp_coord(ax); q.seg_ay = clamp_coord(ay);
    q.seg_bx = clamp_coord(bx); q.seg_by = clamp_coord(by);
    return q;
  endfunction

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  // A segment aimed at a random rectangle, mostly small, sometimes full scale.
  function automatic query_t random_query();
    longint span, rx, ry, rw, rh, m;
    int kind;
    query_t q;
    kind = $urandom_range(9);
    if (kind == 0) begin
      q.rect_x = W'($urandom); q.rect_y = W'($urandom);
      q.rect_w = (W-1)'($urandom); q.rect_h = (W-1)'($urandom);
      q.seg_ax = W'($urandom); q.seg_ay = W'($urandom);
      q.seg_bx = W'($urandom); q.seg_by = W'($urandom);
      return q;
    end
    span = (kind == 1) ? CMAX : ((kind < 4) ? 4096 : 256);
    rx = rand_span(span); ry = rand_span(span);
    rw = $urandom_range(span); rh = $urandom_range(span);
    m = span / 2 + 4;
    q = make_query(rx, ry, rw, rh,
                   rx + rand_span(rw + m), ry + rand_span(rh + m),
                   rx + rand_span(rw + m), ry + rand_span(rh + m));
    case ($urandom_range(7))
      0: q.seg_bx = q.seg_ax;
      1: q.seg_by = q.seg_ay;
      2: begin q.seg_bx = q.seg_ax; q.seg_by = q.seg_ay; end
      default: ;
    endcase
    return q;
  endfunction

  function automatic int random_gap();
    return ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(40);
  endfunction

  // Sender: offers the oldest pending item and records its expected result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      logic accepted;
      logic next_valid;
      accepted = in_valid_i && in_ready_o;
      if (accepted) begin
        crossings_q.push_back(predict_crossings(pending_q.pop_front()));
        send_gap <= ($urandom_range(3) == 0) ? random_gap() : 0;
      end
      next_valid = in_valid_i && !accepted;
      if (!next_valid && pending_q.size() > 0 && (accepted ? 1'b1 : send_gap == 0) &&
          !(accepted && send_gap != 0))
        next_valid = (accepted) ? 1'b0 : 1'b1;
      if (!accepted && !in_valid_i && send_gap > 0) send_gap <= send_gap - 1;
      if (accepted && pending_q.size() > 0 && $urandom_range(3) != 0) next_valid = 1'b1;
      if (next_valid && !(in_valid_i && !accepted)) begin
        rect_x_i <= pending_q[0].rect_x; rect_y_i <= pending_q[0].rect_y;
        rect_w_i <= pending_q[0].rect_w; rect_h_i <= pending_q[0].rect_h;
        seg_ax_i <= pending_q[0].seg_ax; seg_ay_i <= pending_q[0].seg_ay;
        seg_bx_i <= pending_q[0].seg_bx; seg_by_i <= pending_q[0].seg_by;
      end
      in_valid_i <= next_valid;
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps going.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        crossing_t want;
        taken_count++;
        if (crossings_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = crossings_q.pop_front();
          if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
          if (first_x_o !== want.first_x) report_mismatch("first_x", first_x_o, want.first_x);
          if (first_y_o !== want.first_y) report_mismatch("first_y", first_y_o, want.first_y);
          if (second_x_o !== want.second_x)
            report_mismatch("second_x", second_x_o, want.second_x);
          if (second_y_o !== want.second_y)
            report_mismatch("second_y", second_y_o, want.second_y);
        end
      end
      if (!hold_done && taken_count >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= (hold_left == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= (recv_gap == 1);
      end else if (taken_count > 900 && taken_count < 1000) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(3) == 0) begin
        recv_gap <= random_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    query_t q;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    {rect_x_i, rect_y_i, rect_w_i, rect_h_i} = '0;
    {seg_ax_i, seg_ay_i, seg_bx_i, seg_by_i} = '0;
    // Plain diagonal through a square, and its reverse.
    pending_q.push_back(make_query(0, 0, 256, 256, -128, -128, 512, 512));
    pending_q.push_back(make_query(0, 0, 256, 256, 512, 512, -128, -128));
    // Horizontal and vertical segments.
    pending_q.push_back(make_query(-100, -100, 200, 200, -500, 7, 500, 7));
    pending_q.push_back(make_query(-100, -100, 200, 200, -13, -500, -13, 500));
    // Degenerate segment inside the rectangle.
    pending_q.push_back(make_query(0, 0, 100, 100, 50, 50, 50, 50));
    // Line through a corner, and a segment that misses the box.
    pending_q.push_back(make_query(0, 0, 100, 100, -50, 150, 150, -50));
    pending_q.push_back(make_query(0, 0, 100, 100, 200, 200, 300, 400));
    // The segment crosses once and ends inside; its line crosses left and right.
    pending_q.push_back(make_query(0, 0, 100, 100, -50, 30, 50, 40));
    // Extremes: right and bottom beyond the output range.
    pending_q.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    pending_q.push_back(make_query(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    pending_q.push_back(make_query(CMIN, CMIN, 0, 0, CMIN, CMIN, CMAX, CMAX));
    pending_q.push_back(make_query(CMIN, CMIN, CMAX, CMAX, CMIN, 0, CMAX, 1));
    pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_query(CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX));
    pending_q.push_back(make_query(-1, -1, 2, 2, CMIN, CMIN + 3, CMAX, CMAX - 5));
    for (int i = 0; i < 1200; i++) pending_q.push_back(random_query());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid_i && crossings_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
